[hw/rtl/alsr_pkg.sv]
package alsr_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int QUO_W     = 32;
    localparam int MAG_W     = 29;
    // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
    localparam logic [MAG_W-1:0] DIV_MAGIC = 29'd274877907;
    localparam int               DIV_SHIFT = 38;

    // bus event codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_OTHER = 2'd3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_CMD     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CTL     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_THR_HI  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_THR_LO  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SNS_LO  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SNS_HI  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TMR_LO  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_TMR_HI  = 3'd7;

    localparam logic [7:0]  CMD_WR_MASK  = 8'hEF;
    localparam logic [7:0]  CTL_WR_MASK  = 8'h2F;
    localparam int          CTL_IRQ_BIT  = 5;
    localparam logic [7:0]  THR_HI_RESET = 8'hFF;
    localparam logic [7:0]  RD_MISS      = 8'hFF;
    localparam logic [15:0] LUX_RESET    = 16'd500;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic fin;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_wr;
    } t_dp_stat;

    function automatic logic [15:0] max_count(input logic [1:0] sel);
        logic [15:0] m;
        case (sel)
            2'd0:    m = 16'hFFFF;
            2'd1:    m = 16'h0FFF;
            2'd2:    m = 16'h00FF;
            default: m = 16'h000F;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/alsr_in_if.sv]
interface alsr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] write_byte;

    modport source (output valid, output req_type, output write_byte, input ready);
    modport sink   (input valid, input req_type, input write_byte, output ready);
endinterface

[hw/rtl/alsr_out_if.sv]
interface alsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       irq_line;

    modport source (output valid, output read_byte, output irq_line, input ready);
    modport sink   (input valid, input read_byte, input irq_line, output ready);
endinterface

[hw/rtl/ambient_light_sensor_regs_top.sv]
// Channel   Dir  Beat fields              Handshake
// i_in      in   req_type[1:0], write_byte valid/ready
// o_out     out  read_byte[7:0], irq_line  valid/ready
// i_cfg     in   i_cfg_wdata[15:0]         i_cfg_we, no wait
//
// Any bus event but a command-register write goes from idle straight to the response
// state. A command write runs the converter first: the DIV state does the reciprocal
// multiply that divides by 1000, then FIN stores the count. One beat is in flight at a time.
// Reset (synchronous, active low) restores the register file, pointer and lux.
// A stalled output beat holds the block; input is taken as the beat leaves.
module ambient_light_sensor_regs_top
    import alsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    alsr_in_if.sink     i_in,
    alsr_out_if.source  o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    alsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    alsr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_type   (i_in.req_type),
        .i_write_byte (i_in.write_byte),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_read_byte  (o_out.read_byte),
        .o_irq_line   (o_out.irq_line)
    );

endmodule

[hw/rtl/alsr_ctrl.sv]
module alsr_ctrl
    import alsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign o_cmd.accept   = w_accept;
    assign o_cmd.div_step = (r_state == ST_DIV);
    assign o_cmd.fin      = (r_state == ST_FIN);
    assign o_cmd.load_out = (r_state == ST_RESP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_stat.cmd_wr ? ST_DIV : ST_RESP;
                end
            end
            ST_DIV:  n_state = ST_FIN;
            ST_FIN:  n_state = ST_RESP;
            ST_RESP: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    a_fin_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_state == ST_RESP))
        else $error("conversion finish not followed by response");

    a_resp_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) |-> !r_out_valid)
        else $error("response would overwrite a pending beat");

endmodule

[hw/rtl/alsr_dp.sv]
module alsr_dp
    import alsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_write_byte,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic [7:0]  o_read_byte,
    output logic        o_irq_line
);

    logic [7:0]           r_file [REG_COUNT];
    logic [7:0]           r_ptr;
    logic                 r_await;
    logic [15:0]          r_lux;
    logic [7:0]           r_rd;
    logic                 r_en;
    logic [15:0]          r_maxc;
    logic [QUO_W-1:0]     r_quo;
    logic [7:0]           r_read_byte;
    logic                 r_irq_line;

    logic                 w_in_file;
    logic [REG_IDX_W-1:0] w_idx;
    logic [7:0]           w_rd_val;
    logic [15:0]          w_maxc_new;
    logic [31:0]          w_prod;
    logic [1:0]           w_gain;
    logic [QUO_W+MAG_W-1:0] w_recip;
    logic [15:0]          w_count;
    logic [15:0]          w_count_en;
    logic                 w_flag;

    assign w_in_file = (r_ptr < 8'(REG_COUNT));
    assign w_idx     = r_ptr[REG_IDX_W-1:0];
    assign w_rd_val  = w_in_file ? r_file[w_idx] : RD_MISS;

    assign o_stat.cmd_wr   = (i_req_type == REQ_WRITE) && !r_await && w_in_file
                             && (w_idx == REG_CMD);

    // conversion setup: product of lux and full scale, pre-shifted by the gain
    assign w_maxc_new = max_count(i_write_byte[1:0]);
    assign w_gain     = r_file[REG_CTL][3:2];
    assign w_prod     = r_lux * w_maxc_new;

    // divide by 1000 as a multiply by the rounded-up reciprocal
    assign w_recip    = r_quo * DIV_MAGIC;

    assign w_count    = (r_quo > {16'd0, r_maxc}) ? r_maxc : r_quo[15:0];
    assign w_count_en = r_en ? w_count : 16'd0;
    assign w_flag     = r_en && ((w_count > {r_file[REG_THR_HI], 8'h00})
                                 || (w_count < {r_file[REG_THR_LO], 8'h00}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lux <= LUX_RESET;
        end else if (i_cfg_we) begin
            r_lux <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_file[i] <= (i == int'(REG_THR_HI)) ? THR_HI_RESET : 8'h00;
            end
            r_ptr   <= 8'h00;
            r_await <= 1'b0;
        end else if (i_cmd.accept) begin
            case (i_req_type)
                REQ_START: r_await <= 1'b1;
                REQ_WRITE: begin
                    if (r_await) begin
                        r_ptr   <= i_write_byte;
                        r_await <= 1'b0;
                    end else begin
                        r_ptr <= r_ptr + 8'd1;
                        if (w_in_file) begin
                            case (w_idx)
                                REG_CMD:    r_file[REG_CMD] <= i_write_byte & CMD_WR_MASK;
                                REG_CTL:    r_file[REG_CTL] <= i_write_byte & CTL_WR_MASK;
                                REG_THR_HI: r_file[REG_THR_HI] <= i_write_byte;
                                REG_THR_LO: r_file[REG_THR_LO] <= i_write_byte;
                                default:    ;
                            endcase
                        end
                    end
                end
                REQ_READ:  r_ptr <= r_ptr + 8'd1;
                REQ_OTHER: ;
                default:   ;
            endcase
        end else if (i_cmd.fin) begin
            if (w_flag) begin
                r_file[REG_CTL][CTL_IRQ_BIT] <= 1'b1;
            end
            r_file[REG_SNS_LO] <= w_count_en[7:0];
            r_file[REG_SNS_HI] <= w_count_en[15:8];
            r_file[REG_TMR_LO] <= r_en ? r_maxc[7:0]  : 8'h00;
            r_file[REG_TMR_HI] <= r_en ? r_maxc[15:8] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd   <= (i_req_type == REQ_READ) ? w_rd_val : 8'h00;
            r_en   <= i_write_byte[7] && !i_write_byte[6];
            r_maxc <= w_maxc_new;
            r_quo  <= w_prod >> {w_gain, 1'b0};
        end else if (i_cmd.div_step) begin
            r_quo <= QUO_W'(w_recip >> DIV_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_read_byte <= r_rd;
            r_irq_line  <= !r_file[REG_CTL][CTL_IRQ_BIT];
        end
    end

    assign o_read_byte = r_read_byte;
    assign o_irq_line  = r_irq_line;

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && !r_en) |=> (r_file[REG_SNS_LO] == 8'h00 && r_file[REG_SNS_HI] == 8'h00
                                  && r_file[REG_TMR_LO] == 8'h00))
        else $error("disabled conversion left a nonzero count");

    a_count_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && r_en) |=> ({r_file[REG_SNS_HI], r_file[REG_SNS_LO]} <= r_maxc))
        else $error("conversion count above full scale");

    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.accept |=> (r_ptr == $past(r_ptr)))
        else $error("register pointer moved without a bus event");

endmodule

[test/tb_ambient_light_sensor_regs_top.sv]
`timescale 1ns / 1ps

module tb_ambient_light_sensor_regs_top;
    import alsr_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       irq_line;
    } t_sensor_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    alsr_in_if  in_if ();
    alsr_out_if out_if ();

    ambient_light_sensor_regs_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // sensor state as the bus sees it
    logic [7:0]  sns_regs [REG_COUNT];
    logic [7:0]  sns_ptr;
    logic        sns_await;
    logic [15:0] sns_lux;

    t_sensor_reply sensor_reply_q [$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int sent_cnt      = 0;
    int fail_cnt      = 0;
    int quiet_cycles  = 0;
    int hold_cnt      = 0;
    logic hold_req    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void sensor_reset();
        for (int i = 0; i < REG_COUNT; i++) begin
            sns_regs[i] = 8'h00;
        end
        sns_regs[REG_THR_HI] = THR_HI_RESET;
        sns_ptr   = 8'h00;
        sns_await = 1'b0;
        sns_lux   = LUX_RESET;
    endfunction

    function automatic void sensor_convert();
        logic [15:0] maxc;
        logic [1:0]  gain;
        logic        en;
        logic [63:0] quo;
        logic [63:0] scale;
        logic [15:0] cnt;
        case (sns_regs[REG_CMD][1:0])
            2'd0:    maxc = 16'hFFFF;
            2'd1:    maxc = 16'h0FFF;
            2'd2:    maxc = 16'h00FF;
            default: maxc = 16'h000F;
        endcase
        gain  = sns_regs[REG_CTL][3:2];
        en    = sns_regs[REG_CMD][7] && !sns_regs[REG_CMD][6];
        scale = 64'd1000 << (2 * int'(gain));
        quo   = (64'(sns_lux) * 64'(maxc)) / scale;
        cnt   = 16'h0000;
        if (en) begin
            cnt = (quo > 64'(maxc)) ? maxc : quo[15:0];
            // out-of-window count latches the interrupt flag
            if (cnt > {sns_regs[REG_THR_HI], 8'h00} || cnt < {sns_regs[REG_THR_LO], 8'h00}) begin
                sns_regs[REG_CTL][CTL_IRQ_BIT] = 1'b1;
            end
        end
        sns_regs[REG_SNS_LO] = cnt[7:0];
        sns_regs[REG_SNS_HI] = cnt[15:8];
        sns_regs[REG_TMR_LO] = en ? maxc[7:0] : 8'h00;
        sns_regs[REG_TMR_HI] = en ? maxc[15:8] : 8'h00;
    endfunction

    function automatic void sensor_write(input logic [7:0] idx, input logic [7:0] data);
        if (idx < REG_COUNT) begin
            case (idx[REG_IDX_W-1:0])
                REG_CMD: begin
                    sns_regs[REG_CMD] = data & CMD_WR_MASK;
                    sensor_convert();
                end
                REG_CTL:    sns_regs[REG_CTL] = data & CTL_WR_MASK;
                REG_THR_HI: sns_regs[REG_THR_HI] = data;
                REG_THR_LO: sns_regs[REG_THR_LO] = data;
                default: ;
            endcase
        end
    endfunction

    function automatic t_sensor_reply sensor_bus_event(input logic [1:0] req,
                                                       input logic [7:0] data);
        t_sensor_reply r;
        logic [7:0]    idx;
        r.read_byte = 8'h00;
        case (req)
            REQ_START: sns_await = 1'b1;
            REQ_WRITE: begin
                if (sns_await) begin
                    sns_ptr   = data;
                    sns_await = 1'b0;
                end else begin
                    idx     = sns_ptr;
                    sns_ptr = sns_ptr + 8'd1;
                    sensor_write(idx, data);
                end
            end
            REQ_READ: begin
                idx         = sns_ptr;
                sns_ptr     = sns_ptr + 8'd1;
                r.read_byte = (idx < REG_COUNT) ? sns_regs[idx[REG_IDX_W-1:0]] : RD_MISS;
            end
            default: ;
        endcase
        r.irq_line = ~sns_regs[REG_CTL][CTL_IRQ_BIT];
        return r;
    endfunction

    // Leaves valid high on return so back-to-back beats need no extra edge.
    task automatic send_event(input logic [1:0] req, input logic [7:0] data);
        if ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_if.valid      <= 1'b1;
        in_if.req_type   <= req;
        in_if.write_byte <= data;
        do @(posedge i_clk); while (!in_if.ready);
        sensor_reply_q.push_back(sensor_bus_event(req, data));
        sent_cnt++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (sensor_reply_q.size() != 0);
    endtask

    task automatic set_lux(input logic [15:0] lux);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lux;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sns_lux = lux;
    endtask

    // Mostly start + pointer + a burst of reads/writes; the rest is loose events.
    task automatic send_random_transfer();
        logic [7:0] ptr;
        logic [7:0] data;
        int         ops;
        if ($urandom_range(99) < 75) begin
            ptr = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(REG_COUNT));
            send_event(REQ_START, 8'($urandom));
            send_event(REQ_WRITE, ptr);
            ops = $urandom_range(1, 4);
            repeat (ops) begin
                data = 8'($urandom);
                if (ptr == REG_CMD && $urandom_range(1) == 1) data[7:6] = 2'b10;
                if (ptr == REG_THR_LO && $urandom_range(1) == 1) data = data >> 4;
                if ($urandom_range(2) == 0) send_event(REQ_READ, data);
                else send_event(REQ_WRITE, data);
                ptr = ptr + 8'd1;
            end
        end else begin
            send_event(2'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_reset_values();
        send_event(REQ_START, 8'h00);
        send_event(REQ_WRITE, 8'(REG_CMD));
        repeat (REG_COUNT) send_event(REQ_READ, 8'h00);
    endtask

    task automatic test_pointer_edges();
        set_lux(16'hFFFF);
        // read at the top of the pointer range, then wrap to the command register
        send_event(REQ_START, 8'hFF);
        send_event(REQ_WRITE, 8'hFF);
        send_event(REQ_READ, 8'h00);
        send_event(REQ_WRITE, 8'hAB);
        send_event(REQ_OTHER, 8'h5A);
        send_event(REQ_READ, 8'h00);
        // past the file: write dropped, read misses
        send_event(REQ_START, 8'h00);
        send_event(REQ_WRITE, 8'h09);
        send_event(REQ_WRITE, 8'h55);
        send_event(REQ_READ, 8'h00);
    endtask

    task automatic test_irq_latch();
        send_event(REQ_START, 8'h00);
        send_event(REQ_WRITE, 8'(REG_THR_LO));
        send_event(REQ_WRITE, 8'hFF);
        send_event(REQ_START, 8'h00);
        send_event(REQ_WRITE, 8'(REG_CMD));
        send_event(REQ_WRITE, 8'h9C);
        send_event(REQ_READ, 8'h00);
    endtask

    task automatic test_output_hold();
        set_lux(16'd1);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 1'b1;
        fork
            repeat (12) send_random_transfer();
            begin
                wait (hold_cnt >= HOLD_CYCLES);
                hold_req = 1'b0;
            end
        join
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [15:0] lux, input int items);
        int goal;
        set_lux(lux);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        goal = sent_cnt + items;
        while (sent_cnt < goal) send_random_transfer();
    endtask

    // receiver: random stalls, or a long hold-off counted here
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_cnt < HOLD_CYCLES) begin
                out_if.ready <= 1'b0;
                hold_cnt++;
            end else begin
                if (!hold_req) hold_cnt = 0;
                out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_sensor_reply due;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (sensor_reply_q.size() == 0) begin
                $error("unexpected beat: read_byte %h irq_line %b",
                       out_if.read_byte, out_if.irq_line);
                fail_cnt++;
            end else begin
                due = sensor_reply_q.pop_front();
                if (out_if.read_byte !== due.read_byte) begin
                    $error("read_byte: expected %h, got %h", due.read_byte, out_if.read_byte);
                    fail_cnt++;
                end
                if (out_if.irq_line !== due.irq_line) begin
                    $error("irq_line: expected %b, got %b", due.irq_line, out_if.irq_line);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[ambient_light_sensor_regs_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = 16'h0000;
        in_if.valid      = 1'b0;
        in_if.req_type   = REQ_OTHER;
        in_if.write_byte = 8'h00;
        sensor_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_pointer_edges();
        test_irq_latch();
        test_output_hold();
        run_random_phase(0, 0, 16'd0, 250);
        run_random_phase(78, 0, 16'hFFFF, 250);
        run_random_phase(0, 78, 16'($urandom), 250);
        run_random_phase(35, 35, 16'd64000, 250);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && sensor_reply_q.size() == 0) begin
            $display("[ambient_light_sensor_regs_top] OK");
        end else begin
            $display("[ambient_light_sensor_regs_top] ERROR");
        end
        $finish;
    end

endmodule
